>>> hw/rtl/apzp_pkg.sv
package apzp_pkg;

  // One 16-bit two's complement sample or coefficient.
  typedef logic signed [15:0] sample_t;

  // Request to the shared Q15 multiplier.
  typedef struct packed {
    logic    issue;
    sample_t a;
    sample_t b;
  } mul_req_t;

  localparam int C_LEAK_ZERO = 32640;  // zero and a1 leakage factor
  localparam int C_LEAK_A2   = 32512;  // a2 leakage factor
  localparam int C_ZERO_STEP = 128;    // zero coefficient and a2 sign step
  localparam int C_A1_STEP   = 192;    // a1 sign step
  localparam int C_A1_LIM    = 15360;  // a1 bound is this minus a2
  localparam int C_A2_LIM    = 12288;  // a2 bound

  // Saturating 16-bit add.
  function automatic sample_t sat_add16(sample_t a, sample_t b);
    logic signed [16:0] s;
    s = 17'(a) + 17'(b);
    if (s[16] != s[15]) begin
      return s[16] ? 16'sh8000 : 16'sh7fff;
    end
    return s[15:0];
  endfunction

  // Saturating negation: the most negative value maps to the most positive.
  function automatic sample_t sat_neg16(sample_t a);
    return (a == 16'sh8000) ? 16'sh7fff : -a;
  endfunction

  // Sign agreement, with zero counted as positive.
  function automatic logic same_sign(sample_t a, sample_t b);
    return a[15] == b[15];
  endfunction

endpackage

>>> hw/rtl/apzp_mul.sv
module apzp_mul (
  input  logic               clk_i,
  input  apzp_pkg::mul_req_t req_i,
  output apzp_pkg::sample_t  res_o
);
  import apzp_pkg::*;

  logic signed [31:0] prod;
  logic signed [16:0] shifted;
  sample_t            res_d;
  sample_t            res_q;

  // Q15 product with floor truncation; only -1 times -1 can overflow.
  assign prod    = req_i.a * req_i.b;
  assign shifted = prod[31:15];

  always_comb begin
    if (shifted[16] != shifted[15]) begin
      res_d = shifted[16] ? 16'sh8000 : 16'sh7fff;
    end else begin
      res_d = shifted[15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.issue) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

>>> hw/rtl/adpcm_pole_zero_predictor.sv
// Adaptive pole-zero predictor of one ADPCM sub-band.
//
// The slave channel carries one quantized difference sample per beat. For
// each beat the block returns one beat on the master channel holding the new
// full prediction, the new zero-part prediction and the reconstructed sample.
// All arithmetic runs through a single registered Q15 multiplier under a
// small sequencer: every multiply has an issue state and a state that
// consumes the product. The result is offered at the same edge at which
// the block becomes ready again, and the input is not ready while an item
// is in work.
// The result sits in an output register, so a new item is accepted while the
// previous result still waits. If the receiver stalls so long that the next
// result is finished before the old one is taken, the sequencer holds in its
// last step until the output register is free.
// Reset clears all histories, coefficients and predictions to zero and
// drops the output valid.
module adpcm_pole_zero_predictor #(
  parameter int ZERO_TAPS = 6
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [15:0] s_tdata_i,   // [15:0] quant_diff
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [47:0] m_tdata_o    // [15:0] prediction, [31:16] zero_prediction,
                                   // [47:32] reconstructed
);
  import apzp_pkg::*;

  localparam int IdxW = (ZERO_TAPS > 1) ? $clog2(ZERO_TAPS) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(ZERO_TAPS - 1);

  // Each multiply step has an issue state and a state that uses the product.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ZC_MUL,
    ST_ZC_UPD,
    ST_A2_MUL,
    ST_A2_UPD,
    ST_A1_MUL,
    ST_A1_UPD,
    ST_ZS_MUL,
    ST_ZS_ACC,
    ST_P1_MUL,
    ST_P1_UPD,
    ST_P2_MUL,
    ST_P2_UPD
  } state_e;

  state_e          state_q;
  logic [IdxW-1:0] idx_q;

  // Per-item working registers.
  sample_t d_q;
  sample_t recon_q;
  sample_t partial_q;
  sample_t w_q;
  sample_t lim_q;
  sample_t zsum_q;
  sample_t t1_q;

  // Predictor state.
  sample_t dh_q [ZERO_TAPS];
  sample_t zc_q [ZERO_TAPS];
  sample_t pole_q [2];
  sample_t ph_q [2];
  sample_t prev_recon_q;
  sample_t prev_pred_q;
  sample_t prev_zp_q;

  // Output register.
  logic    m_valid_q;
  sample_t out_pred_q;
  sample_t out_zp_q;
  sample_t out_recon_q;

  mul_req_t mul_req;
  sample_t  mul_res;

  // Combinational helpers for the update steps.
  sample_t d_in;
  sample_t zc_step;
  sample_t zc_sign_step;
  sample_t a2_w0;
  sample_t a2_w1;
  sample_t a2_w;
  sample_t a2_sum;
  sample_t a2_new;
  sample_t a1_lim;
  sample_t a1_sum;
  sample_t a1_new;
  sample_t pred_new;
  logic    out_free;

  assign d_in     = s_tdata_i;
  assign out_free = !m_valid_q || m_tready_i;

  // The shared multiplier sees one operand pair per issue state.
  always_comb begin
    mul_req = '0;
    case (state_q)
      ST_ZC_MUL: begin
        mul_req.issue = 1'b1;
        mul_req.a     = zc_q[idx_q];
        mul_req.b     = sample_t'(C_LEAK_ZERO);
      end
      ST_A2_MUL: begin
        mul_req.issue = 1'b1;
        mul_req.a     = sample_t'(C_LEAK_A2);
        mul_req.b     = pole_q[1];
      end
      ST_A1_MUL: begin
        mul_req.issue = 1'b1;
        mul_req.a     = sample_t'(C_LEAK_ZERO);
        mul_req.b     = pole_q[0];
      end
      ST_ZS_MUL: begin
        mul_req.issue = 1'b1;
        mul_req.a     = sat_add16(dh_q[idx_q], dh_q[idx_q]);
        mul_req.b     = zc_q[idx_q];
      end
      ST_P1_MUL: begin
        mul_req.issue = 1'b1;
        mul_req.a     = sat_add16(recon_q, recon_q);
        mul_req.b     = pole_q[0];
      end
      ST_P2_MUL: begin
        mul_req.issue = 1'b1;
        mul_req.a     = sat_add16(prev_recon_q, prev_recon_q);
        mul_req.b     = pole_q[1];
      end
      default: begin
        mul_req = '0;
      end
    endcase
  end

  apzp_mul u_mul (
    .clk_i (clk_i),
    .req_i (mul_req),
    .res_o (mul_res)
  );

  always_comb begin
    // Sign-sign step of the zero coefficients; a zero difference only leaks.
    zc_step      = (d_q == '0) ? sample_t'(0) : sample_t'(C_ZERO_STEP);
    zc_sign_step = same_sign(dh_q[idx_q], d_q) ? zc_step : -zc_step;

    // Gradient term of a2, prepared while its leakage product is formed.
    a2_w0 = sat_add16(pole_q[0], pole_q[0]);
    if (same_sign(partial_q, ph_q[0])) begin
      a2_w0 = sat_neg16(a2_w0);
    end
    a2_w1 = a2_w0 >>> 7;
    a2_w  = sat_add16(same_sign(partial_q, ph_q[1]) ? sample_t'(C_ZERO_STEP)
                                                    : sample_t'(-C_ZERO_STEP),
                      a2_w1);

    a2_sum = sat_add16(w_q, mul_res);
    if (a2_sum > sample_t'(C_A2_LIM)) begin
      a2_new = sample_t'(C_A2_LIM);
    end else if (a2_sum < sample_t'(-C_A2_LIM)) begin
      a2_new = sample_t'(-C_A2_LIM);
    end else begin
      a2_new = a2_sum;
    end

    // The a1 bound follows the freshly updated a2.
    a1_lim = sat_add16(sample_t'(C_A1_LIM), sat_neg16(pole_q[1]));
    a1_sum = sat_add16(same_sign(partial_q, ph_q[0]) ? sample_t'(C_A1_STEP)
                                                     : sample_t'(-C_A1_STEP),
                       mul_res);
    if (a1_sum > lim_q) begin
      a1_new = lim_q;
    end else if (a1_sum < sat_neg16(lim_q)) begin
      a1_new = sat_neg16(lim_q);
    end else begin
      a1_new = a1_sum;
    end

    pred_new = sat_add16(sat_add16(t1_q, mul_res), zsum_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      idx_q        <= '0;
      m_valid_q    <= 1'b0;
      prev_recon_q <= '0;
      prev_pred_q  <= '0;
      prev_zp_q    <= '0;
      for (int i = 0; i < ZERO_TAPS; i++) begin
        dh_q[i] <= '0;
        zc_q[i] <= '0;
      end
      for (int i = 0; i < 2; i++) begin
        pole_q[i] <= '0;
        ph_q[i]   <= '0;
      end
    end else begin
      // A beat taken by the receiver clears the valid unless a new result
      // loads the output register at the same edge.
      if (m_tready_i && !((state_q == ST_P2_UPD) && out_free)) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (s_tvalid_i) begin
            d_q       <= d_in;
            recon_q   <= sat_add16(prev_pred_q, d_in);
            partial_q <= sat_add16(d_in, prev_zp_q);
            idx_q     <= '0;
            state_q   <= ST_ZC_MUL;
          end
        end
        ST_ZC_MUL: begin
          state_q <= ST_ZC_UPD;
        end
        ST_ZC_UPD: begin
          zc_q[idx_q] <= sat_add16(zc_sign_step, mul_res);
          if (idx_q == LastIdx) begin
            idx_q   <= '0;
            state_q <= ST_A2_MUL;
          end else begin
            idx_q   <= idx_q + IdxW'(1);
            state_q <= ST_ZC_MUL;
          end
        end
        ST_A2_MUL: begin
          w_q     <= a2_w;
          state_q <= ST_A2_UPD;
        end
        ST_A2_UPD: begin
          pole_q[1] <= a2_new;
          state_q   <= ST_A1_MUL;
        end
        ST_A1_MUL: begin
          lim_q   <= a1_lim;
          state_q <= ST_A1_UPD;
        end
        ST_A1_UPD: begin
          pole_q[0] <= a1_new;
          // Histories move on once every coefficient has used the old ones.
          for (int i = ZERO_TAPS - 1; i > 0; i--) begin
            dh_q[i] <= dh_q[i-1];
          end
          dh_q[0] <= d_q;
          ph_q[1] <= ph_q[0];
          ph_q[0] <= partial_q;
          zsum_q  <= '0;
          idx_q   <= '0;
          state_q <= ST_ZS_MUL;
        end
        ST_ZS_MUL: begin
          state_q <= ST_ZS_ACC;
        end
        ST_ZS_ACC: begin
          zsum_q <= sat_add16(zsum_q, mul_res);
          if (idx_q == LastIdx) begin
            idx_q   <= '0;
            state_q <= ST_P1_MUL;
          end else begin
            idx_q   <= idx_q + IdxW'(1);
            state_q <= ST_ZS_MUL;
          end
        end
        ST_P1_MUL: begin
          state_q <= ST_P1_UPD;
        end
        ST_P1_UPD: begin
          t1_q    <= mul_res;
          state_q <= ST_P2_MUL;
        end
        ST_P2_MUL: begin
          state_q <= ST_P2_UPD;
        end
        ST_P2_UPD: begin
          if (out_free) begin
            m_valid_q    <= 1'b1;
            out_pred_q   <= pred_new;
            out_zp_q     <= zsum_q;
            out_recon_q  <= recon_q;
            prev_pred_q  <= pred_new;
            prev_zp_q    <= zsum_q;
            prev_recon_q <= recon_q;
            state_q      <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign s_tready_o = (state_q == ST_IDLE);
  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = {out_recon_q, out_zp_q, out_pred_q};

`ifndef SYNTHESIS
  // The stability clamp keeps a2 inside its bound at all times.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pole_q[1] <= sample_t'(C_A2_LIM)) && (pole_q[1] >= sample_t'(-C_A2_LIM)))
    else $error("a2 outside its stability bound");

  // a1 never exceeds the widest bound its clamp allows.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pole_q[0] <= sample_t'(C_A1_LIM + C_A2_LIM)) &&
    (pole_q[0] >= sample_t'(-(C_A1_LIM + C_A2_LIM))))
    else $error("a1 outside its stability bound");

  // A result only appears as the last step of an item completes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(state_q == ST_P2_UPD))
    else $error("result raised outside the final step");

  // An accepted sample keeps the input closed on the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_tvalid_i && s_tready_o) |=> !s_tready_o)
    else $error("input reopened while a sample is in work");

  // The tap counter stays within the tap count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= LastIdx)
    else $error("tap index out of range");
`endif

endmodule
